// File: sv/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg: shared definitions for the wheel speed pid block
// Operation codes, register map, reset values, stream widths and the divider status word.
// ----------------------------------------------------------------------------
package wsp_pkg;

    // default number of fraction bits in the gain registers
    localparam int GAIN_FRAC_BITS_DEF = 16;

    // stream widths
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 40;

    // operation codes
    localparam logic [2:0] OP_EDGE   = 3'd0;
    localparam logic [2:0] OP_WINDOW = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_START  = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;

    // register indexes (byte address is 4 times the index)
    localparam logic [2:0] REG_GAIN_PROP    = 3'd0;
    localparam logic [2:0] REG_GAIN_INTEG   = 3'd1;
    localparam logic [2:0] REG_GAIN_DERIV   = 3'd2;
    localparam logic [2:0] REG_SETPOINT     = 3'd3;
    localparam logic [2:0] REG_PWM_MAX      = 3'd4;
    localparam logic [2:0] REG_PWM_DEFAULT  = 3'd5;
    localparam logic [2:0] REG_SPEED_SCALE  = 3'd6;

    // register reset values
    localparam logic [23:0] GAIN_PROP_RST    = 24'd163840;
    localparam logic [23:0] GAIN_INTEG_RST   = 24'd197;
    localparam logic [23:0] GAIN_DERIV_RST   = 24'd0;
    localparam logic [15:0] SETPOINT_RST     = 16'd300;
    localparam logic [15:0] PWM_MAX_RST      = 16'd10000;
    localparam logic [15:0] PWM_DEFAULT_RST  = 16'd5000;
    localparam logic [9:0]  SPEED_SCALE_RST  = 10'd10;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: sv/wheel_speed_pid.sv
// ----------------------------------------------------------------------------
// wheel_speed_pid: speed loop for one wheel
// Counts encoder edges, measures speed per window and runs an incremental
// pid on a pwm level with one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
//  channel   | direction | words / fields
//  ----------+-----------+----------------------------------------------
//  s_axis    | in        | tuser: operation, tdata: elapsed_ms
//  m_axis    | out       | tdata: pwm_level, speed_now, running
//  apb       | in/out    | seven control registers at 4*index
//
//  edge, start, stop and unused codes pass through decode and done, window
//  end adds the speed saturation step. a control tick runs the multiply,
//  term and clamp steps and is lengthened mostly by the serial divider of
//  the derivative term; a tick with zero elapsed time skips the divider.
//  reset is synchronous and clears the loop state at once, no sweep.
//  s_tready is high only while idle; a finished word waits in the output
//  register, and the next word is taken meanwhile.
// ----------------------------------------------------------------------------
module wheel_speed_pid #(
    parameter int GAIN_FRAC_BITS = wsp_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [wsp_pkg::S_DATA_W-1:0] s_tdata,  // [15:0] elapsed_ms
    input  logic [wsp_pkg::S_USER_W-1:0] s_tuser,  // [2:0] operation
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [wsp_pkg::M_DATA_W-1:0] m_tdata,  // [15:0] pwm_level,
                                                   // [31:16] speed_now,
                                                   // [32] running, zero above
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int DIV_W = 42 - GAIN_FRAC_BITS;
    localparam int SUM_W = 58;
    localparam logic signed [SUM_W-1:0] RND =
        (SUM_W'(1) <<< GAIN_FRAC_BITS) - SUM_W'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_WIN_SAT, S_MUL_ACC, S_ACC_SAT, S_P_TERM,
        S_I_TERM, S_D_MUL, S_DIV, S_CLAMP, S_DONE
    } state_t;

    state_t state_reg, state_next;

    // control registers
    logic [23:0] gain_prop_reg, gain_prop_next;
    logic [23:0] gain_integ_reg, gain_integ_next;
    logic [23:0] gain_deriv_reg, gain_deriv_next;
    logic [15:0] target_reg, target_next;
    logic [15:0] pwm_max_reg, pwm_max_next;
    logic [15:0] pwm_def_reg, pwm_def_next;
    logic [9:0]  scale_reg, scale_next;

    // loop state
    logic [15:0]        edge_cnt_reg, edge_cnt_next;
    logic [15:0]        speed_reg, speed_next;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [16:0] prev_err_reg, prev_err_next;
    logic [15:0]        pwm_reg, pwm_next;
    logic               run_reg, run_next;

    // working registers
    logic [2:0]              op_reg, op_next;
    logic [15:0]             el_reg, el_next;
    logic signed [16:0]      err_reg, err_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    d_neg_reg, d_neg_next;
    logic signed [56:0]      prod_reg;

    // output register
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [wsp_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;

    // shared multiplier and helpers
    logic [23:0]             mul_a;
    logic signed [32:0]      mul_b;
    logic signed [56:0]      mul_p;
    logic signed [17:0]      derr;
    logic signed [33:0]      acc_sum;
    logic signed [SUM_W-1:0] prod_ext;
    logic signed [SUM_W-1:0] term_rnd;
    logic signed [SUM_W-1:0] term;
    logic [56:0]             mag;
    logic signed [SUM_W-1:0] q_ext;

    // divider
    logic                div_start;
    logic [DIV_W-1:0]    div_quo;
    wsp_pkg::div_stat_t  div_stat;

    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // register read back
    always_comb begin
        unique case (paddr[4:2])
            wsp_pkg::REG_GAIN_PROP:    prdata = {8'd0, gain_prop_reg};
            wsp_pkg::REG_GAIN_INTEG:   prdata = {8'd0, gain_integ_reg};
            wsp_pkg::REG_GAIN_DERIV:   prdata = {8'd0, gain_deriv_reg};
            wsp_pkg::REG_SETPOINT:     prdata = {16'd0, target_reg};
            wsp_pkg::REG_PWM_MAX:      prdata = {16'd0, pwm_max_reg};
            wsp_pkg::REG_PWM_DEFAULT:  prdata = {16'd0, pwm_def_reg};
            wsp_pkg::REG_SPEED_SCALE:  prdata = {22'd0, scale_reg};
            default:                   prdata = '0;
        endcase
    end

    // operand select for the shared multiplier
    assign derr = {err_reg[16], err_reg} - {prev_err_reg[16], prev_err_reg};

    always_comb begin
        case (state_reg)
            S_MUL_ACC: begin
                mul_a = {8'd0, el_reg};
                mul_b = {{16{err_reg[16]}}, err_reg};
            end
            S_ACC_SAT: begin
                mul_a = gain_prop_reg;
                mul_b = {{16{err_reg[16]}}, err_reg};
            end
            S_P_TERM: begin
                mul_a = gain_integ_reg;
                mul_b = {integ_reg[31], integ_reg};
            end
            S_I_TERM: begin
                mul_a = gain_deriv_reg;
                mul_b = {{15{derr[17]}}, derr};
            end
            default: begin
                mul_a = {14'd0, scale_reg};
                mul_b = {17'd0, edge_cnt_reg};
            end
        endcase
    end

    assign mul_p = $signed({33'd0, mul_a}) * $signed({{24{mul_b[32]}}, mul_b});

    // integral update and gain term truncation toward zero
    assign acc_sum  = {{2{integ_reg[31]}}, integ_reg} + $signed(prod_reg[33:0]);
    assign prod_ext = {prod_reg[56], prod_reg};
    assign term_rnd = prod_ext + (prod_reg[56] ? RND : SUM_W'(0));
    assign term     = term_rnd >>> GAIN_FRAC_BITS;

    // derivative magnitude for the divider
    assign mag   = prod_reg[56] ? 57'(-prod_reg) : prod_reg;
    assign q_ext = $signed({{(SUM_W-DIV_W){1'b0}}, div_quo});

    wsp_divider #(
        .DIV_W(DIV_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(mag[GAIN_FRAC_BITS +: DIV_W]),
        .divisor (el_reg),
        .quotient(div_quo),
        .stat    (div_stat)
    );

    // sequencer and next state
    always_comb begin
        state_next      = state_reg;
        gain_prop_next  = gain_prop_reg;
        gain_integ_next = gain_integ_reg;
        gain_deriv_next = gain_deriv_reg;
        target_next     = target_reg;
        pwm_max_next    = pwm_max_reg;
        pwm_def_next    = pwm_def_reg;
        scale_next      = scale_reg;
        edge_cnt_next   = edge_cnt_reg;
        speed_next      = speed_reg;
        integ_next      = integ_reg;
        prev_err_next   = prev_err_reg;
        pwm_next        = pwm_reg;
        run_next        = run_reg;
        op_next         = op_reg;
        el_next         = el_reg;
        err_next        = err_reg;
        sum_next        = sum_reg;
        d_neg_next      = d_neg_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_data_next   = out_data_reg;
        div_start       = 1'b0;

        // register writes
        if (cfg_wr) begin
            unique case (paddr[4:2])
                wsp_pkg::REG_GAIN_PROP:    gain_prop_next  = pwdata[23:0];
                wsp_pkg::REG_GAIN_INTEG:   gain_integ_next = pwdata[23:0];
                wsp_pkg::REG_GAIN_DERIV:   gain_deriv_next = pwdata[23:0];
                wsp_pkg::REG_SETPOINT:     target_next     = pwdata[15:0];
                wsp_pkg::REG_PWM_MAX:      pwm_max_next    = pwdata[15:0];
                wsp_pkg::REG_PWM_DEFAULT:  pwm_def_next    = pwdata[15:0];
                wsp_pkg::REG_SPEED_SCALE:  scale_next      = pwdata[9:0];
                default: ;
            endcase
        end

        // result word taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    el_next    = s_tdata;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_DONE;
                unique case (op_reg)
                    wsp_pkg::OP_EDGE: begin
                        if (edge_cnt_reg != 16'hFFFF) begin
                            edge_cnt_next = edge_cnt_reg + 16'd1;
                        end
                    end
                    wsp_pkg::OP_WINDOW: begin
                        state_next = S_WIN_SAT;
                    end
                    wsp_pkg::OP_TICK: begin
                        if (run_reg) begin
                            err_next   = $signed({1'b0, target_reg}) -
                                         $signed({1'b0, speed_reg});
                            state_next = S_MUL_ACC;
                        end
                    end
                    wsp_pkg::OP_START: begin
                        integ_next    = '0;
                        prev_err_next = '0;
                        pwm_next      = pwm_def_reg;
                        run_next      = 1'b1;
                    end
                    wsp_pkg::OP_STOP: begin
                        integ_next    = '0;
                        prev_err_next = '0;
                        pwm_next      = pwm_def_reg;
                        run_next      = 1'b0;
                    end
                    default: ;
                endcase
            end
            S_WIN_SAT: begin
                speed_next    = (|prod_reg[56:16]) ? 16'hFFFF : prod_reg[15:0];
                edge_cnt_next = '0;
                state_next    = S_DONE;
            end
            S_MUL_ACC: begin
                state_next = S_ACC_SAT;
            end
            S_ACC_SAT: begin
                // saturate the integral to 32 bits
                if (!acc_sum[33] && (acc_sum[32:31] != 2'b00)) begin
                    integ_next = 32'sh7FFF_FFFF;
                end else if (acc_sum[33] && (acc_sum[32:31] != 2'b11)) begin
                    integ_next = 32'sh8000_0000;
                end else begin
                    integ_next = acc_sum[31:0];
                end
                state_next = S_P_TERM;
            end
            S_P_TERM: begin
                sum_next   = $signed({42'd0, pwm_reg}) + term;
                state_next = S_I_TERM;
            end
            S_I_TERM: begin
                sum_next   = sum_reg + term;
                state_next = S_D_MUL;
            end
            S_D_MUL: begin
                if (el_reg == 16'd0) begin
                    state_next = S_CLAMP;
                end else begin
                    d_neg_next = prod_reg[56];
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    sum_next   = d_neg_reg ? (sum_reg - q_ext) : (sum_reg + q_ext);
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP: begin
                if (sum_reg[SUM_W-1]) begin
                    pwm_next = '0;
                end else if (sum_reg > $signed({42'd0, pwm_max_reg})) begin
                    pwm_next = pwm_max_reg;
                end else begin
                    pwm_next = sum_reg[15:0];
                end
                prev_err_next = err_reg;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    out_data_next = {7'd0, run_reg, speed_reg, pwm_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        prod_reg      <= mul_p;
        op_reg        <= op_next;
        el_reg        <= el_next;
        err_reg       <= err_next;
        sum_reg       <= sum_next;
        d_neg_reg     <= d_neg_next;
        out_data_reg  <= out_data_next;
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            gain_prop_reg  <= wsp_pkg::GAIN_PROP_RST;
            gain_integ_reg <= wsp_pkg::GAIN_INTEG_RST;
            gain_deriv_reg <= wsp_pkg::GAIN_DERIV_RST;
            target_reg     <= wsp_pkg::SETPOINT_RST;
            pwm_max_reg    <= wsp_pkg::PWM_MAX_RST;
            pwm_def_reg    <= wsp_pkg::PWM_DEFAULT_RST;
            scale_reg      <= wsp_pkg::SPEED_SCALE_RST;
            edge_cnt_reg   <= '0;
            speed_reg      <= '0;
            integ_reg      <= '0;
            prev_err_reg   <= '0;
            pwm_reg        <= wsp_pkg::PWM_DEFAULT_RST;
            run_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            gain_prop_reg  <= gain_prop_next;
            gain_integ_reg <= gain_integ_next;
            gain_deriv_reg <= gain_deriv_next;
            target_reg     <= target_next;
            pwm_max_reg    <= pwm_max_next;
            pwm_def_reg    <= pwm_def_next;
            scale_reg      <= scale_next;
            edge_cnt_reg   <= edge_cnt_next;
            speed_reg      <= speed_next;
            integ_reg      <= integ_next;
            prev_err_reg   <= prev_err_next;
            pwm_reg        <= pwm_next;
            run_reg        <= run_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // an accepted word always goes to decode next
    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_DECODE)
        else $error("accepted word did not enter decode");

    // the divider only finishes while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide step");

    // run flag changes only on decode of an operation
    a_run_only_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_DECODE |=> $stable(run_reg))
        else $error("run flag changed outside decode");

    // edge counter holds at full scale
    a_edge_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DECODE && op_reg == wsp_pkg::OP_EDGE &&
        edge_cnt_reg == 16'hFFFF |=> edge_cnt_reg == 16'hFFFF)
        else $error("edge counter wrapped");

    // clamp keeps the level within the maximum
    a_pwm_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLAMP |=> pwm_reg <= pwm_max_reg)
        else $error("pwm level above maximum after clamp");
`endif

endmodule

// File: sv/wsp_divider.sv
// ----------------------------------------------------------------------------
// wsp_divider: serial unsigned divider
// Restoring division, one quotient bit per cycle, 16 bit divisor.
// ----------------------------------------------------------------------------
module wsp_divider #(
    parameter int DIV_W = 26
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_W-1:0]   dividend,
    input  logic [15:0]        divisor,
    output logic [DIV_W-1:0]   quotient,
    output wsp_pkg::div_stat_t stat
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [16:0]      rem_sh;
    logic [16:0]      rem_sub;
    logic             q_bit;

    // one restoring step
    assign rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign q_bit   = (rem_sh >= {1'b0, dvs_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-2:0], q_bit};
            rem_next = q_bit ? rem_sub[15:0] : rem_sh[15:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for wheel_speed_pid
// Drives operation words on the input stream and register writes on the apb
// port, predicts every result word with a cycle-free model of the speed loop
// and compares each field of the result stream in order. Directed words
// cover the corner cases, then random segments run under several gain
// settings and idle patterns, and an edge burst overflows the scaled speed.
// ----------------------------------------------------------------------------
module tb;

    localparam int     STALL_LIMIT  = 20000;
    localparam int     HOLDOFF      = 60;
    localparam int     SEG_WORDS    = 156;
    localparam int     SEG_COUNT    = 8;
    localparam int     OVF_EDGES    = 70;
    localparam longint I32_MAX      = 64'sd2147483647;
    localparam longint I32_MIN      = -64'sd2147483648;
    localparam logic [2:0] OP_UNUSED_LO = wsp_pkg::OP_STOP + 3'd1;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    // expected result words of the speed loop, kept in arrival order
    class pid_loop_scoreboard;
        typedef struct {
            logic [15:0] pwm_level;
            logic [15:0] speed_now;
            logic        running;
        } loop_word_t;

        // register copies
        logic [23:0] gain_prop, gain_integ, gain_deriv;
        logic [15:0] speed_setpoint, pwm_max, pwm_default;
        logic [9:0]  speed_scale;
        // loop state
        logic [15:0] edge_count, speed_reg, pwm_reg;
        longint      integral_acc, prev_error;
        logic        run_flag;

        loop_word_t  expected_words[$];
        int          mismatches;

        function new();
            gain_prop      = wsp_pkg::GAIN_PROP_RST;
            gain_integ     = wsp_pkg::GAIN_INTEG_RST;
            gain_deriv     = wsp_pkg::GAIN_DERIV_RST;
            speed_setpoint = wsp_pkg::SETPOINT_RST;
            pwm_max        = wsp_pkg::PWM_MAX_RST;
            pwm_default    = wsp_pkg::PWM_DEFAULT_RST;
            speed_scale    = wsp_pkg::SPEED_SCALE_RST;
            edge_count     = '0;
            speed_reg      = '0;
            pwm_reg        = wsp_pkg::PWM_DEFAULT_RST;
            integral_acc   = 0;
            prev_error     = 0;
            run_flag       = 1'b0;
            mismatches     = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                wsp_pkg::REG_GAIN_PROP:   gain_prop      = value[23:0];
                wsp_pkg::REG_GAIN_INTEG:  gain_integ     = value[23:0];
                wsp_pkg::REG_GAIN_DERIV:  gain_deriv     = value[23:0];
                wsp_pkg::REG_SETPOINT:    speed_setpoint = value[15:0];
                wsp_pkg::REG_PWM_MAX:     pwm_max        = value[15:0];
                wsp_pkg::REG_PWM_DEFAULT: pwm_default    = value[15:0];
                wsp_pkg::REG_SPEED_SCALE: speed_scale    = value[9:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void reload();
            integral_acc = 0;
            prev_error   = 0;
            pwm_reg      = pwm_default;
        endfunction

        // incremental pid step, each term truncated toward zero
        function void apply_tick(logic [15:0] elapsed_ms);
            longint one, ms, tgt, spd, err, acc, gp, gi, gd, p, i, d, lvl, lvl_max;
            one = longint'(1) << wsp_pkg::GAIN_FRAC_BITS_DEF;
            ms  = elapsed_ms;
            tgt = speed_setpoint;
            spd = speed_reg;
            gp  = gain_prop;
            gi  = gain_integ;
            gd  = gain_deriv;
            err = tgt - spd;

            acc = integral_acc + err * ms;
            if (acc > I32_MAX) acc = I32_MAX;
            if (acc < I32_MIN) acc = I32_MIN;
            integral_acc = acc;

            p = (gp * err) / one;
            i = (gi * integral_acc) / one;
            d = 0;
            if (ms != 0) d = (gd * (err - prev_error)) / (one * ms);

            lvl     = pwm_reg;
            lvl     = lvl + p + i + d;
            lvl_max = pwm_max;
            if (lvl < 0) lvl = 0;
            if (lvl > lvl_max) lvl = lvl_max;
            pwm_reg    = lvl[15:0];
            prev_error = err;
        endfunction

        // accepted input word: update the loop and queue its result
        function void note_word(logic [2:0] op, logic [15:0] elapsed_ms);
            longint     scaled, cnt, scl;
            loop_word_t w;
            case (op)
                wsp_pkg::OP_EDGE: begin
                    if (edge_count != 16'hFFFF) edge_count = edge_count + 16'd1;
                end
                wsp_pkg::OP_WINDOW: begin
                    cnt    = edge_count;
                    scl    = speed_scale;
                    scaled = cnt * scl;
                    if (scaled > 65535) scaled = 65535;
                    speed_reg  = scaled[15:0];
                    edge_count = '0;
                end
                wsp_pkg::OP_TICK: begin
                    if (run_flag) apply_tick(elapsed_ms);
                end
                wsp_pkg::OP_START: begin
                    reload();
                    run_flag = 1'b1;
                end
                wsp_pkg::OP_STOP: begin
                    reload();
                    run_flag = 1'b0;
                end
                default: ;
            endcase
            w.pwm_level = pwm_reg;
            w.speed_now = speed_reg;
            w.running   = run_flag;
            expected_words.push_back(w);
        endfunction

        // accepted result word: compare with the oldest expectation
        function void check_word(logic [wsp_pkg::M_DATA_W-1:0] data);
            loop_word_t w;
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: %h", data);
                mismatches++;
                return;
            end
            w = expected_words.pop_front();
            if (data[15:0] !== w.pwm_level) begin
                $error("pwm_level: expected %0d, got %0d", w.pwm_level, data[15:0]);
                mismatches++;
            end
            if (data[31:16] !== w.speed_now) begin
                $error("speed_now: expected %0d, got %0d", w.speed_now, data[31:16]);
                mismatches++;
            end
            if (data[32] !== w.running) begin
                $error("running: expected %0d, got %0d", w.running, data[32]);
                mismatches++;
            end
            if (data[wsp_pkg::M_DATA_W-1:33] !== '0) begin
                $error("padding: expected 0, got %h", data[wsp_pkg::M_DATA_W-1:33]);
                mismatches++;
            end
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [wsp_pkg::S_DATA_W-1:0] s_tdata;   // [15:0] elapsed_ms
    logic [wsp_pkg::S_USER_W-1:0] s_tuser;   // [2:0] operation
    logic                         m_tvalid;
    logic                         m_tready;
    // [15:0] pwm_level, [31:16] speed_now, [32] running
    logic [wsp_pkg::M_DATA_W-1:0] m_tdata;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [4:0]                   paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    int                  send_idle_pct;
    int                  recv_stall_pct;
    pid_loop_scoreboard  sb;

    wheel_speed_pid u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // result checking
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata);
    end

    // watchdog on cycles with no word moving on either stream
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // one input word, with random idle cycles ahead of it
    task automatic send_word(input logic [2:0] op, input logic [15:0] ms);
        @(negedge aclk);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = ms;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(op, ms);
    endtask

    // apb write: setup cycle, then access cycle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // hold the sender until every result is back and the block is idle
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (HOLDOFF) @(posedge aclk);
    endtask

    function automatic logic [15:0] random_ms();
        int r;
        r = $urandom_range(99, 0);
        if (r < 15) return 16'd0;
        if (r < 65) return 16'($urandom_range(50, 1));
        if (r < 85) return 16'($urandom_range(1000, 51));
        if (r < 95) return 16'($urandom);
        return 16'hFFFF;
    endfunction

    function automatic logic [31:0] random_gain(input int bits);
        int r;
        r = $urandom_range(9, 0);
        if (r == 0) return 32'd0;
        if (r == 1) return 32'hFF_FFFF;
        return 32'($urandom_range((1 << bits) - 1, 0));
    endfunction

    // new register setting, written while the block is idle
    task automatic load_random_config();
        logic [15:0] pmax;
        int          r;
        wait_drained();
        write_reg(wsp_pkg::REG_GAIN_PROP,  random_gain(18));
        write_reg(wsp_pkg::REG_GAIN_INTEG, random_gain(10));
        write_reg(wsp_pkg::REG_GAIN_DERIV, random_gain(20));
        r = $urandom_range(9, 0);
        write_reg(wsp_pkg::REG_SETPOINT,
                  (r == 0) ? 32'hFFFF : 32'($urandom_range(3000, 0)));
        r = $urandom_range(9, 0);
        if (r == 0) pmax = 16'd1;
        else if (r == 1) pmax = 16'hFFFF;
        else pmax = 16'($urandom_range(20000, 1000));
        write_reg(wsp_pkg::REG_PWM_MAX, {16'd0, pmax});
        r = $urandom_range(9, 0);
        write_reg(wsp_pkg::REG_PWM_DEFAULT,
                  (r == 0) ? 32'hFFFF : 32'($urandom_range(pmax, 0)));
        r = $urandom_range(9, 0);
        write_reg(wsp_pkg::REG_SPEED_SCALE,
                  (r == 0) ? 32'd1023 : 32'($urandom_range(1000, 1)));
    endtask

    // mostly running loop traffic: edge bursts, windows and ticks, with some starts, stops and unused codes
    task automatic run_random_segment(input int count, input bit pause_mid);
        int sent, burst, r;
        bit paused;
        sent   = 1;
        paused = 1'b0;
        send_word(wsp_pkg::OP_START, random_ms());
        while (sent < count) begin
            if (pause_mid && !paused && sent >= count / 2) begin
                paused = 1'b1;
                wait_drained();
            end
            r = $urandom_range(99, 0);
            if (r < 45) begin
                burst = $urandom_range(8, 1);
                repeat (burst) send_word(wsp_pkg::OP_EDGE, 16'($urandom));
                sent += burst;
            end else begin
                if (r < 60) send_word(wsp_pkg::OP_WINDOW, 16'($urandom));
                else if (r < 88) send_word(wsp_pkg::OP_TICK, random_ms());
                else if (r < 92) send_word(wsp_pkg::OP_START, 16'($urandom));
                else if (r < 95) send_word(wsp_pkg::OP_STOP, 16'($urandom));
                else send_word(3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)),
                               16'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        int seg;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = wsp_pkg::OP_EDGE;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sb             = new();
        aresetn        = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: every operation at reset settings
        send_word(OP_UNUSED_LO, 16'hA5A5);
        send_word(wsp_pkg::OP_TICK, 16'd10);          // tick while stopped
        send_word(wsp_pkg::OP_EDGE, 16'h0000);
        send_word(wsp_pkg::OP_EDGE, 16'hFFFF);
        send_word(wsp_pkg::OP_EDGE, 16'h1234);
        send_word(wsp_pkg::OP_WINDOW, 16'd0);
        send_word(wsp_pkg::OP_START, 16'd0);
        send_word(wsp_pkg::OP_TICK, 16'd0);           // zero elapsed time
        send_word(wsp_pkg::OP_TICK, 16'd20);
        send_word(wsp_pkg::OP_TICK, 16'hFFFF);
        send_word(wsp_pkg::OP_EDGE, 16'd0);
        send_word(wsp_pkg::OP_WINDOW, 16'd0);
        send_word(wsp_pkg::OP_START, 16'd0);          // start while running
        send_word(wsp_pkg::OP_STOP, 16'd0);
        send_word(wsp_pkg::OP_STOP, 16'd0);           // stop while stopped
        send_word(wsp_pkg::OP_TICK, 16'd5);
        send_word(OP_UNUSED_LO + 3'd1, 16'd0);
        send_word(OP_UNUSED_HI, 16'hFFFF);
        send_word(wsp_pkg::OP_START, 16'd0);
        send_word(wsp_pkg::OP_TICK, 16'd1);

        // maximum gains, zero scale, positive integral saturation
        wait_drained();
        write_reg(wsp_pkg::REG_GAIN_PROP, 32'hFF_FFFF);
        write_reg(wsp_pkg::REG_GAIN_INTEG, 32'hFF_FFFF);
        write_reg(wsp_pkg::REG_GAIN_DERIV, 32'hFF_FFFF);
        write_reg(wsp_pkg::REG_SETPOINT, 32'hFFFF);
        write_reg(wsp_pkg::REG_PWM_MAX, 32'hFFFF);
        write_reg(wsp_pkg::REG_PWM_DEFAULT, 32'hFFFF);
        write_reg(wsp_pkg::REG_SPEED_SCALE, 32'd0);
        send_word(wsp_pkg::OP_EDGE, 16'd0);
        send_word(wsp_pkg::OP_WINDOW, 16'd0);
        send_word(wsp_pkg::OP_START, 16'd0);
        send_word(wsp_pkg::OP_TICK, 16'hFFFF);
        send_word(wsp_pkg::OP_TICK, 16'd0);
        send_word(wsp_pkg::OP_TICK, 16'd1);
        send_word(wsp_pkg::OP_STOP, 16'd0);

        // zero target, zero level limit, negative error and integral
        wait_drained();
        write_reg(wsp_pkg::REG_SETPOINT, 32'd0);
        write_reg(wsp_pkg::REG_SPEED_SCALE, 32'd1000);
        write_reg(wsp_pkg::REG_PWM_MAX, 32'd0);
        write_reg(wsp_pkg::REG_PWM_DEFAULT, 32'd0);
        repeat (3) send_word(wsp_pkg::OP_EDGE, 16'($urandom));
        send_word(wsp_pkg::OP_WINDOW, 16'd0);
        send_word(wsp_pkg::OP_START, 16'd0);
        send_word(wsp_pkg::OP_TICK, 16'hFFFF);
        send_word(wsp_pkg::OP_TICK, 16'd7);
        send_word(wsp_pkg::OP_STOP, 16'd0);

        // random segments under the four idle patterns
        for (seg = 0; seg < SEG_COUNT; seg++) begin
            load_random_config();
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            run_random_segment(SEG_WORDS, seg == 1);
        end

        // scaled speed overflow
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(wsp_pkg::REG_SPEED_SCALE, 32'd1023);
        repeat (OVF_EDGES) send_word(wsp_pkg::OP_EDGE, 16'($urandom));
        send_word(wsp_pkg::OP_WINDOW, 16'd0);
        send_word(wsp_pkg::OP_START, 16'd0);
        send_word(wsp_pkg::OP_TICK, 16'd3);

        wait_drained();
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
